// File: rtl/i2cm_pkg.sv
// Shared types, command codes and status codes for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

	// Function codes carried by an input item
	localparam logic [2:0] FUNC_TICK  = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_STOP  = 3'd2;
	localparam logic [2:0] FUNC_WRITE = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;
	localparam logic [2:0] FUNC_RESET = 3'd5;

	// Active command code for no command in progress
	localparam logic [2:0] CMD_IDLE = 3'd0;

	// Result status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NACK   = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	// Half period phase codes within one command
	localparam logic [1:0] PH_A   = 2'd0;
	localparam logic [1:0] PH_B   = 2'd1;
	localparam logic [1:0] PH_AK0 = 2'd2;
	localparam logic [1:0] PH_AK1 = 2'd3;

	localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;
	localparam logic [3:0]  RESET_PULSES     = 4'd9;
	localparam logic [15:0] HALF_PERIOD_INIT = 16'd250;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] data_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} out_item_t;

endpackage

// File: rtl/i2cm_if.sv
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps

interface i2cm_in_if;
	logic              valid;
	logic              ready;
	i2cm_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_out_if;
	logic               valid;
	logic               ready;
	i2cm_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: command sequencer and result register.
//
//   channel   dir   transfer                       payload
//   item      in    valid & ready at rising clk    func, data_byte, send_ack, sda_in
//   result    out   valid & ready at rising clk    scl_level, sda_level, busy_res,
//                                                  done_res, status, read_data
//   cfg       in    cfg_we at rising clk           cfg_wdata = half_period_ticks
//
// One item per clock while item.ready is high: the sequencer state and the result register update in the
// same cycle an item transfers, so every item's result is valid the next cycle.
// The single result register sets the latency; item.ready stays high while that
// register is empty or being drained, so a stalled result blocks only new items.
// arst_n clears the sequencer to idle with both pins released and the half period
// at 250 ticks; the result register comes up empty.
`timescale 1ns / 1ps

module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	i2cm_in_if.sink     item,
	i2cm_out_if.source  result
);

	// Configuration
	logic [15:0] half_q;

	// Sequencer state
	logic [15:0] tick_q;
	logic [1:0]  phase_q;
	logic [3:0]  bit_q;
	logic [7:0]  shift_q;
	logic [2:0]  cmd_q;
	logic        ack_q;
	logic        scl_q;
	logic        sda_q;

	// Result register
	logic                valid_q;
	i2cm_pkg::out_item_t res_q;

	// Next state
	logic [15:0] tick_d;
	logic [1:0]  phase_d;
	logic [3:0]  bit_d;
	logic [7:0]  shift_d;
	logic [2:0]  cmd_d;
	logic        ack_d;
	logic        scl_d;
	logic        sda_d;
	i2cm_pkg::out_item_t res_d;

	logic        accept;
	logic        is_cmd;
	logic [15:0] limit;
	logic [16:0] tick_inc;
	logic [3:0]  bit_inc;
	logic        fin;

	// Pin levels for a half period: returns {scl, sda}. SDA holds on bus reset.
	function automatic logic [1:0] pins(input logic [2:0] cmd, input logic [1:0] ph,
			input logic msb, input logic ackc, input logic scl_cur, input logic sda_cur);
		logic [1:0] p;
		p = {scl_cur, sda_cur};
		case (cmd)
			i2cm_pkg::FUNC_START: p = {1'b1, ph == i2cm_pkg::PH_A};
			i2cm_pkg::FUNC_STOP:  p = {ph != i2cm_pkg::PH_A, 1'b0};
			i2cm_pkg::FUNC_WRITE: begin
				if (ph == i2cm_pkg::PH_A || ph == i2cm_pkg::PH_B)
					p = {ph == i2cm_pkg::PH_A, msb};
				else
					p = {ph == i2cm_pkg::PH_AK1, 1'b1};
			end
			i2cm_pkg::FUNC_READ: begin
				if (ph == i2cm_pkg::PH_A || ph == i2cm_pkg::PH_B)
					p = {ph == i2cm_pkg::PH_A, 1'b1};
				else
					p = {ph == i2cm_pkg::PH_AK1, ~ackc};
			end
			i2cm_pkg::FUNC_RESET: p = {ph == i2cm_pkg::PH_A, sda_cur};
			default: p = {scl_cur, sda_cur};
		endcase
		return p;
	endfunction

	assign accept     = item.valid & item.ready;
	assign item.ready = ~valid_q | result.ready;
	assign result.valid   = valid_q;
	assign result.payload = res_q;

	assign is_cmd   = item.payload.func inside {[i2cm_pkg::FUNC_START : i2cm_pkg::FUNC_RESET]};
	// A zero half period acts as one tick
	assign limit    = (half_q == 16'd0) ? 16'd1 : half_q;
	assign tick_inc = {1'b0, tick_q} + 17'd1;
	assign bit_inc  = bit_q + 4'd1;

	always_comb begin
		tick_d  = tick_q;
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		cmd_d   = cmd_q;
		ack_d   = ack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		fin     = 1'b0;
		res_d   = '0;

		if (is_cmd) begin
			if (cmd_q != i2cm_pkg::CMD_IDLE) begin
				// Drop a command that arrives mid-transfer; timing does not advance
				res_d.status = i2cm_pkg::STATUS_REJECT;
			end else begin
				cmd_d   = item.payload.func;
				phase_d = i2cm_pkg::PH_A;
				bit_d   = 4'd0;
				tick_d  = 16'd0;
				shift_d = (item.payload.func == i2cm_pkg::FUNC_WRITE) ?
					item.payload.data_byte : 8'd0;
				ack_d   = item.payload.send_ack;
				{scl_d, sda_d} = pins(item.payload.func, i2cm_pkg::PH_A,
					item.payload.data_byte[7], item.payload.send_ack, scl_q, sda_q);
			end
		end else if (cmd_q != i2cm_pkg::CMD_IDLE) begin
			if (tick_inc >= {1'b0, limit}) begin
				tick_d = 16'd0;
				// End of a half period: advance phase, shift and bit count
				case (cmd_q)
					i2cm_pkg::FUNC_START, i2cm_pkg::FUNC_STOP: begin
						if (phase_q == i2cm_pkg::PH_A) begin
							phase_d = i2cm_pkg::PH_B;
						end else begin
							fin = 1'b1;
							scl_d = (cmd_q == i2cm_pkg::FUNC_STOP);
							sda_d = (cmd_q == i2cm_pkg::FUNC_STOP);
						end
					end
					i2cm_pkg::FUNC_WRITE: begin
						case (phase_q)
							i2cm_pkg::PH_A: phase_d = i2cm_pkg::PH_B;
							i2cm_pkg::PH_B: begin
								shift_d = {shift_q[6:0], 1'b0};
								bit_d   = bit_inc;
								phase_d = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
									i2cm_pkg::PH_AK0 : i2cm_pkg::PH_A;
							end
							i2cm_pkg::PH_AK0: phase_d = i2cm_pkg::PH_AK1;
							default: begin
								// Sample the slave's ACK on the last high tick
								fin = 1'b1;
								scl_d = 1'b0;
								sda_d = 1'b1;
								res_d.status = item.payload.sda_in ?
									i2cm_pkg::STATUS_NACK : i2cm_pkg::STATUS_OK;
							end
						endcase
					end
					i2cm_pkg::FUNC_READ: begin
						case (phase_q)
							i2cm_pkg::PH_A: begin
								shift_d = {shift_q[6:0], item.payload.sda_in};
								phase_d = i2cm_pkg::PH_B;
							end
							i2cm_pkg::PH_B: begin
								bit_d   = bit_inc;
								phase_d = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
									i2cm_pkg::PH_AK0 : i2cm_pkg::PH_A;
							end
							i2cm_pkg::PH_AK0: phase_d = i2cm_pkg::PH_AK1;
							default: begin
								fin = 1'b1;
								scl_d = 1'b0;
								sda_d = ~ack_q;
								res_d.read_data = shift_q;
							end
						endcase
					end
					i2cm_pkg::FUNC_RESET: begin
						if (phase_q == i2cm_pkg::PH_A) begin
							phase_d = i2cm_pkg::PH_B;
						end else begin
							bit_d = bit_inc;
							if (bit_inc >= i2cm_pkg::RESET_PULSES) begin
								fin = 1'b1;
								scl_d = 1'b0;
							end else begin
								phase_d = i2cm_pkg::PH_A;
							end
						end
					end
					default: fin = 1'b1;
				endcase

				if (fin) begin
					res_d.done_res = 1'b1;
					cmd_d   = i2cm_pkg::CMD_IDLE;
					phase_d = i2cm_pkg::PH_A;
					bit_d   = 4'd0;
				end else begin
					{scl_d, sda_d} = pins(cmd_q, phase_d, shift_d[7], ack_q, scl_q, sda_q);
				end
			end else begin
				tick_d = tick_inc[15:0];
			end
		end

		res_d.scl_level = scl_d;
		res_d.sda_level = sda_d;
		res_d.busy_res  = (cmd_d != i2cm_pkg::CMD_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= i2cm_pkg::HALF_PERIOD_INIT;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	// Advance the sequencer on every item transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= 16'd0;
			phase_q <= i2cm_pkg::PH_A;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			cmd_q   <= i2cm_pkg::CMD_IDLE;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (accept) begin
			tick_q  <= tick_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			cmd_q   <= cmd_d;
			ack_q   <= ack_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

endmodule

// File: tb/tb_i2c_master_byte_engine.sv
// Self-checking testbench for the I2C master byte engine: directed and random command streams.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
	import i2cm_pkg::*;

	// Spare function codes; the engine treats them as ticks
	localparam logic [2:0] FUNC_SPARE6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE7 = 3'd7;

	// How the sampled SDA level is chosen on tick items
	localparam int SDA_LOW  = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;

	localparam int RANDOM_ITEMS = 820;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD    = 320;
	// Ticks offered at the largest half period; far too few to finish a half
	localparam int MAX_HP_TICKS = 150;
	// Longest command: eight data bits plus the acknowledge slot, two halves each
	localparam int HALVES_MAX   = 2 * int'(BITS_PER_BYTE) + 2;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	i2cm_in_if  item_ch ();
	i2cm_out_if result_ch ();

	i2c_master_byte_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_ch),
		.result   (result_ch)
	);

	// Shared run control
	int fail_count  = 0;
	int items_sent  = 0;
	int hp_setting  = int'(HALF_PERIOD_INIT);
	bit idle_en     = 1'b1;
	bit hold_req    = 1'b0;
	int stuck       = 0;

	// Engine model state, advanced once per accepted item
	logic [15:0] hp_ticks = HALF_PERIOD_INIT;
	logic [15:0] tick_cnt = '0;
	logic [1:0]  ph       = PH_A;
	logic [3:0]  bit_idx  = '0;
	logic [7:0]  shreg    = '0;
	logic [2:0]  cur_cmd  = CMD_IDLE;
	logic        ack_sel  = 1'b0;
	logic        scl_q    = 1'b1;
	logic        sda_q    = 1'b1;

	// Results predicted for accepted items, oldest first
	out_item_t pin_results[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Set the pin levels for the half period that just began.
	function automatic void drive_pins();
		case (cur_cmd)
			FUNC_START: begin
				scl_q = 1'b1;
				sda_q = (ph == PH_A);
			end
			FUNC_STOP: begin
				sda_q = 1'b0;
				scl_q = (ph != PH_A);
			end
			FUNC_WRITE: begin
				if (ph <= PH_B) begin
					scl_q = (ph == PH_A);
					sda_q = shreg[7];
				end else begin
					// release SDA so the slave can answer
					scl_q = (ph == PH_AK1);
					sda_q = 1'b1;
				end
			end
			FUNC_READ: begin
				if (ph <= PH_B) begin
					scl_q = (ph == PH_A);
					sda_q = 1'b1;
				end else begin
					scl_q = (ph == PH_AK1);
					sda_q = !ack_sel;
				end
			end
			FUNC_RESET: scl_q = (ph == PH_A);
			default: ;
		endcase
	endfunction

	// Advance the engine state by one item and return the pin and status result.
	function automatic out_item_t predict_pins(input in_item_t it);
		out_item_t   r;
		logic        fin;
		logic        nack;
		logic [2:0]  cmd;
		logic [15:0] lim;
		logic [16:0] nxt;
		r    = '0;
		fin  = 1'b0;
		nack = 1'b0;
		cmd  = cur_cmd;
		if (it.func >= FUNC_START && it.func <= FUNC_RESET) begin
			if (cur_cmd != CMD_IDLE) begin
				// busy: drop the command, timing does not move
				r.status = STATUS_REJECT;
			end else begin
				cur_cmd  = it.func;
				ph       = PH_A;
				bit_idx  = '0;
				tick_cnt = '0;
				shreg    = (it.func == FUNC_WRITE) ? it.data_byte : 8'h00;
				ack_sel  = it.send_ack;
				drive_pins();
			end
		end else if (cur_cmd != CMD_IDLE) begin
			// a zero half period behaves as one tick
			lim = (hp_ticks == 16'd0) ? 16'd1 : hp_ticks;
			nxt = {1'b0, tick_cnt} + 17'd1;
			if (nxt >= {1'b0, lim}) begin
				tick_cnt = '0;
				case (cur_cmd)
					FUNC_START, FUNC_STOP: begin
						if (ph == PH_A) begin
							ph = PH_B;
						end else begin
							fin   = 1'b1;
							scl_q = (cur_cmd == FUNC_STOP);
							sda_q = (cur_cmd == FUNC_STOP);
						end
					end
					FUNC_WRITE: begin
						case (ph)
							PH_A: ph = PH_B;
							PH_B: begin
								shreg   = {shreg[6:0], 1'b0};
								bit_idx = bit_idx + 4'd1;
								ph      = (bit_idx >= BITS_PER_BYTE) ? PH_AK0 : PH_A;
							end
							PH_AK0: ph = PH_AK1;
							default: begin
								nack  = it.sda_in;
								scl_q = 1'b0;
								sda_q = 1'b1;
								fin   = 1'b1;
							end
						endcase
					end
					FUNC_READ: begin
						case (ph)
							PH_A: begin
								shreg = {shreg[6:0], it.sda_in};
								ph    = PH_B;
							end
							PH_B: begin
								bit_idx = bit_idx + 4'd1;
								ph      = (bit_idx >= BITS_PER_BYTE) ? PH_AK0 : PH_A;
							end
							PH_AK0: ph = PH_AK1;
							default: begin
								scl_q = 1'b0;
								sda_q = !ack_sel;
								fin   = 1'b1;
							end
						endcase
					end
					FUNC_RESET: begin
						if (ph == PH_A) begin
							ph = PH_B;
						end else begin
							bit_idx = bit_idx + 4'd1;
							if (bit_idx >= RESET_PULSES) begin
								scl_q = 1'b0;
								fin   = 1'b1;
							end else begin
								ph = PH_A;
							end
						end
					end
					default: fin = 1'b1;
				endcase
				if (fin) begin
					r.done_res = 1'b1;
					if (cmd == FUNC_WRITE)
						r.status = nack ? STATUS_NACK : STATUS_OK;
					if (cmd == FUNC_READ)
						r.read_data = shreg;
					cur_cmd = CMD_IDLE;
					ph      = PH_A;
					bit_idx = '0;
				end else begin
					drive_pins();
				end
			end else begin
				tick_cnt = nxt[15:0];
			end
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res  = (cur_cmd != CMD_IDLE);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Watch both channels and the config port at every edge. Predict on the
	// input transfer first so a result in the same cycle still finds its entry.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			hp_ticks = HALF_PERIOD_INIT;
			tick_cnt = '0;
			ph       = PH_A;
			bit_idx  = '0;
			shreg    = '0;
			cur_cmd  = CMD_IDLE;
			ack_sel  = 1'b0;
			scl_q    = 1'b1;
			sda_q    = 1'b1;
			pin_results.delete();
		end else begin
			if (cfg_we)
				hp_ticks = cfg_wdata;
			if (item_ch.valid && item_ch.ready)
				pin_results.push_back(predict_pins(item_ch.payload));
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.payload;
				if (pin_results.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					want = pin_results.pop_front();
					check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
					check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
					check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(got.done_res));
					check_field("status", 8'(want.status), 8'(got.status));
					check_field("read_data", want.read_data, got.read_data);
				end
			end
		end
	end

	// Result sink: random stall bursts, plus one long hold-off on request that
	// this process counts down itself.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 11) == 0) begin
				result_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing has moved for too long.
	initial begin
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
				stuck = 0;
			else
				stuck++;
			if (stuck >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic in_item_t rand_item(input logic [2:0] f);
		in_item_t it;
		it.func      = f;
		it.data_byte = 8'($urandom);
		it.send_ack  = 1'($urandom);
		it.sda_in    = 1'($urandom);
		return it;
	endfunction

	function automatic int halves_of(input logic [2:0] f);
		if (f == FUNC_START || f == FUNC_STOP)
			return 2;
		if (f == FUNC_RESET)
			return 2 * int'(RESET_PULSES);
		return HALVES_MAX;
	endfunction

	// Offer one item and hold it until the transfer. Called at a clock edge;
	// returns at the edge of the transfer with valid still high.
	task automatic send_item(input in_item_t it);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	// Send n tick-like items. With noise, commands that land while busy are
	// mixed in; they are rejected and do not count as ticks.
	task automatic send_ticks(input int n, input int sda_mode, input bit noisy);
		in_item_t   it;
		logic [2:0] f;
		for (int k = 0; k < n; k++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(rand_item(3'($urandom_range(FUNC_START, FUNC_RESET))));
			case ($urandom_range(0, 9))
				0: f = FUNC_SPARE6;
				1: f = FUNC_SPARE7;
				default: f = FUNC_TICK;
			endcase
			it = rand_item(f);
			if (sda_mode == SDA_LOW)
				it.sda_in = 1'b0;
			else if (sda_mode == SDA_HIGH)
				it.sda_in = 1'b1;
			send_item(it);
		end
	endtask

	// Issue one command and exactly the ticks it needs to finish.
	task automatic run_command(input logic [2:0] f, input logic [7:0] data, input logic ack,
			input int sda_mode, input bit noisy);
		in_item_t it;
		it           = rand_item(f);
		it.data_byte = data;
		it.send_ack  = ack;
		send_item(it);
		send_ticks(halves_of(f) * ((hp_setting == 0) ? 1 : hp_setting), sda_mode, noisy);
	endtask

	// Stop offering, wait for every outstanding result, then let the pipe settle.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pin_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_half_period(input logic [15:0] v);
		wait_drained();
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		hp_setting = int'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Ticks while idle change nothing; then a start at the reset half period.
	task automatic test_default_half_period();
		send_item(rand_item(FUNC_TICK));
		send_item(rand_item(FUNC_SPARE6));
		send_item(rand_item(FUNC_SPARE7));
		run_command(FUNC_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
	endtask

	// Zero acts as one tick per half; walk every command and the data extremes.
	task automatic test_zero_half_period();
		set_half_period(16'd0);
		run_command(FUNC_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
		run_command(FUNC_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0);
		run_command(FUNC_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0);
		run_command(FUNC_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
		run_command(FUNC_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
		run_command(FUNC_RESET, 8'h5A, 1'b1, SDA_RAND, 1'b0);
		run_command(FUNC_STOP, 8'hA5, 1'b0, SDA_RAND, 1'b0);
	endtask

	// Every command code offered while a write is still in flight.
	task automatic test_busy_reject();
		set_half_period(16'd1);
		send_item(rand_item(FUNC_WRITE));
		for (int f = FUNC_START; f <= FUNC_RESET; f++)
			send_item(rand_item(3'(f)));
		send_ticks(HALVES_MAX, SDA_RAND, 1'b0);
	endtask

	// Hold the result side off for a long stretch while items keep coming,
	// then pause the sender until everything has drained.
	task automatic test_backpressure();
		set_half_period(16'd2);
		hold_req = 1'b1;
		run_command(FUNC_WRITE, 8'($urandom), 1'b0, SDA_RAND, 1'b1);
		run_command(FUNC_READ, 8'h00, 1'($urandom), SDA_RAND, 1'b1);
		wait_drained();
	endtask

	// Phases at random small half periods; mostly complete commands, some junk.
	task automatic test_random_sequences();
		int stop_at;
		int hp;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: hp = 0;
				1: hp = $urandom_range(5, 12);
				default: hp = $urandom_range(1, 3);
			endcase
			set_half_period(16'(hp));
			idle_en = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(5, 15)) begin
				if (items_sent >= stop_at)
					break;
				if ($urandom_range(0, 6) == 0) begin
					// broken sequence: anything goes, then enough ticks to finish
					// whatever command it may have started
					repeat ($urandom_range(1, 6))
						send_item(rand_item(3'($urandom_range(0, 7))));
					send_ticks(HALVES_MAX * ((hp == 0) ? 1 : hp), SDA_RAND, 1'b0);
				end else begin
					run_command(3'($urandom_range(FUNC_START, FUNC_RESET)), 8'($urandom),
						1'($urandom), SDA_RAND, 1'b1);
					send_ticks($urandom_range(0, 3), SDA_RAND, 1'b0);
				end
			end
		end
		idle_en = 1'b1;
	endtask

	// Largest half period, run back to back with no idling on either side. The
	// stop stays in its first half; the tick counter climbs well away from zero.
	task automatic test_max_half_period();
		idle_en = 1'b0;
		set_half_period(16'hFFFF);
		send_item(rand_item(FUNC_STOP));
		send_ticks(MAX_HP_TICKS, SDA_RAND, 1'b1);
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		item_ch.valid   <= 1'b0;
		item_ch.payload <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_half_period();
		test_zero_half_period();
		test_busy_reject();
		test_backpressure();
		test_random_sequences();
		test_max_half_period();
		wait_drained();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
